// ----- hw/rtl/crc_checked_request_frame_receiver_core_assert.svh -----
// Assertion macros used by the frame engine RTL.
// All of them sample on the rising edge of clk and are off while rst is high.
`ifndef CRC_CHECKED_REQUEST_FRAME_RECEIVER_CORE_ASSERT_SVH
`define CRC_CHECKED_REQUEST_FRAME_RECEIVER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CCRFR_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: expression does not hold");
`define CCRFR_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define CCRFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define CCRFR_ASSERT_ALWAYS(label, expr)
`define CCRFR_ASSERT_IMPLIES(label, ante, cons)
`define CCRFR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hw/rtl/ccrfr_pkg.sv -----
package ccrfr_pkg;

  localparam int HEADER_BYTES  = 20;
  localparam int PAYLOAD_LIMIT = 4096;
  localparam int IDX_W         = 13;
  localparam int HDR_IDX_W     = $clog2(HEADER_BYTES);
  localparam int CRC_SPAN      = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [IDX_W-1:0] HDR_LAST_IDX = IDX_W'(HEADER_BYTES - 1);
  localparam logic [IDX_W-1:0] CRC_SPAN_IDX = IDX_W'(CRC_SPAN);
  localparam logic [31:0]      MAX_LEN      = 32'(PAYLOAD_LIMIT);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [15:0] TIMEOUT_RESET = 16'd30000;

  // header byte offsets
  localparam int OFS_MAGIC   = 0;
  localparam int OFS_VERSION = 4;
  localparam int OFS_TYPE    = 5;
  localparam int OFS_FLAGS   = 6;
  localparam int OFS_SEQ     = 8;
  localparam int OFS_LEN     = 12;
  localparam int OFS_CRC     = 16;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  typedef enum logic [2:0] {
    V_NONE     = 3'd0,
    V_DISPATCH = 3'd1,
    V_REPLAY   = 3'd2,
    V_BAD      = 3'd3,
    V_CRC      = 3'd4
  } verdict_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic             passthrough;
    logic             payload_valid;
    logic [7:0]       out_byte;
    verdict_t         verdict;
    logic [6:0]       req_type;
    logic [31:0]      req_sequence;
    logic [IDX_W-1:0] req_length;
  } result_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/ccrfr_in_stage.sv -----
module ccrfr_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ccrfr_pkg::item_t     in_item,
  input  logic                 take,
  input  logic                 slot_free,
  output logic                 item_valid,
  output ccrfr_pkg::item_t     item
);

  assign in_ready = !item_valid || slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ----- hw/rtl/ccrfr_frame_engine.sv -----
`include "crc_checked_request_frame_receiver_core_assert.svh"

module ccrfr_frame_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ccrfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             fire,
  input  ccrfr_pkg::item_t                 item,
  output logic                             res_valid,
  output ccrfr_pkg::result_t               res
);

  // configuration
  logic [31:0] frame_magic;
  logic [7:0]  hdr_version;
  logic [15:0] timeout_ticks;

  // frame state
  ccrfr_pkg::phase_t             phase, phase_next;
  logic [ccrfr_pkg::IDX_W-1:0]   byte_index, byte_index_next;
  logic [31:0]                   running_crc, running_crc_next;
  logic [15:0]                   idle_ticks, idle_ticks_next;
  logic                          cache_valid, cache_valid_next;
  logic [31:0]                   cache_sequence, cache_sequence_next;
  logic [6:0]                    cache_type, cache_type_next;
  logic [31:0]                   cache_crc, cache_crc_next;
  logic [7:0]                    header_store [ccrfr_pkg::HEADER_BYTES];

  logic [7:0]                    hdr_view [ccrfr_pkg::HEADER_BYTES];
  logic [7:0]                    b;
  logic                          is_byte;
  logic [6:0]                    f_type;
  logic [31:0]                   f_seq;
  logic [31:0]                   f_len;
  logic [31:0]                   f_crc;
  logic                          header_ok;
  logic [31:0]                   crc_upd;
  logic [ccrfr_pkg::IDX_W-1:0]   idx_inc;
  logic                          finish;
  logic                          finish_pv;
  logic                          hdr_idx_ok;
  logic                          replay_fire;
  logic                          pass_clean;

  assign b       = item.rx_byte;
  assign is_byte = (item.opcode == ccrfr_pkg::OP_BYTE);

  // header as it stands after this byte lands
  always_comb begin
    for (int i = 0; i < ccrfr_pkg::HEADER_BYTES; i++) begin
      hdr_view[i] = (phase == ccrfr_pkg::PH_HEADER && is_byte &&
                     byte_index == ccrfr_pkg::IDX_W'(i)) ? b : header_store[i];
    end
  end

  assign f_type = hdr_view[ccrfr_pkg::OFS_TYPE][6:0];
  assign f_seq  = {hdr_view[ccrfr_pkg::OFS_SEQ+3], hdr_view[ccrfr_pkg::OFS_SEQ+2],
                   hdr_view[ccrfr_pkg::OFS_SEQ+1], hdr_view[ccrfr_pkg::OFS_SEQ]};
  assign f_len  = {hdr_view[ccrfr_pkg::OFS_LEN+3], hdr_view[ccrfr_pkg::OFS_LEN+2],
                   hdr_view[ccrfr_pkg::OFS_LEN+1], hdr_view[ccrfr_pkg::OFS_LEN]};
  assign f_crc  = {hdr_view[ccrfr_pkg::OFS_CRC+3], hdr_view[ccrfr_pkg::OFS_CRC+2],
                   hdr_view[ccrfr_pkg::OFS_CRC+1], hdr_view[ccrfr_pkg::OFS_CRC]};

  assign header_ok =
    ({hdr_view[ccrfr_pkg::OFS_MAGIC+3], hdr_view[ccrfr_pkg::OFS_MAGIC+2],
      hdr_view[ccrfr_pkg::OFS_MAGIC+1], hdr_view[ccrfr_pkg::OFS_MAGIC]} == frame_magic) &&
    (hdr_view[ccrfr_pkg::OFS_VERSION] == hdr_version) &&
    !hdr_view[ccrfr_pkg::OFS_TYPE][7] &&
    (hdr_view[ccrfr_pkg::OFS_FLAGS] == 8'h00) &&
    (hdr_view[ccrfr_pkg::OFS_FLAGS+1] == 8'h00);

  assign idx_inc = byte_index + ccrfr_pkg::IDX_W'(1);

  always_comb begin
    phase_next          = phase;
    byte_index_next     = byte_index;
    running_crc_next    = running_crc;
    idle_ticks_next     = idle_ticks;
    cache_valid_next    = cache_valid;
    cache_sequence_next = cache_sequence;
    cache_type_next     = cache_type;
    cache_crc_next      = cache_crc;
    crc_upd             = running_crc;
    finish              = 1'b0;
    finish_pv           = 1'b0;
    res_valid           = 1'b0;
    res                 = '0;

    if (!is_byte) begin
      if (phase != ccrfr_pkg::PH_IDLE) begin
        if (idle_ticks >= timeout_ticks) begin
          phase_next      = ccrfr_pkg::PH_IDLE;
          byte_index_next = '0;
          idle_ticks_next = '0;
          if (phase == ccrfr_pkg::PH_PAYLOAD) begin
            cache_valid_next = 1'b0;
            res_valid        = 1'b1;
            res.verdict      = ccrfr_pkg::V_BAD;
            res.req_type     = f_type;
            res.req_sequence = f_seq;
            res.req_length   = f_len[ccrfr_pkg::IDX_W-1:0];
          end
        end else begin
          idle_ticks_next = idle_ticks + 16'd1;
        end
      end
    end else begin
      idle_ticks_next = '0;
      case (phase)
        ccrfr_pkg::PH_IDLE: begin
          if (b != frame_magic[7:0]) begin
            res_valid       = 1'b1;
            res.passthrough = 1'b1;
            res.out_byte    = b;
          end else begin
            running_crc_next = ccrfr_pkg::crc_feed(ccrfr_pkg::CRC_INIT, b);
            byte_index_next  = ccrfr_pkg::IDX_W'(1);
            phase_next       = ccrfr_pkg::PH_HEADER;
          end
        end
        ccrfr_pkg::PH_HEADER: begin
          if (byte_index < ccrfr_pkg::CRC_SPAN_IDX) begin
            crc_upd = ccrfr_pkg::crc_feed(running_crc, b);
          end
          running_crc_next = crc_upd;
          byte_index_next  = idx_inc;
          if (byte_index == ccrfr_pkg::HDR_LAST_IDX) begin
            phase_next      = ccrfr_pkg::PH_IDLE;
            byte_index_next = '0;
            if (header_ok) begin
              if (f_len > ccrfr_pkg::MAX_LEN) begin
                cache_valid_next = 1'b0;
                res_valid        = 1'b1;
                res.verdict      = ccrfr_pkg::V_BAD;
                res.req_type     = f_type;
                res.req_sequence = f_seq;
              end else if (f_len == 32'd0) begin
                finish = 1'b1;
              end else begin
                phase_next = ccrfr_pkg::PH_PAYLOAD;
              end
            end
          end
        end
        ccrfr_pkg::PH_PAYLOAD: begin
          crc_upd          = ccrfr_pkg::crc_feed(running_crc, b);
          running_crc_next = crc_upd;
          byte_index_next  = idx_inc;
          if (idx_inc < f_len[ccrfr_pkg::IDX_W-1:0]) begin
            res_valid         = 1'b1;
            res.payload_valid = 1'b1;
            res.out_byte      = b;
          end else begin
            finish    = 1'b1;
            finish_pv = 1'b1;
          end
        end
        default: begin
          phase_next      = ccrfr_pkg::PH_IDLE;
          byte_index_next = '0;
        end
      endcase
    end

    // end of frame: CRC check, then duplicate lookup
    if (finish) begin
      phase_next        = ccrfr_pkg::PH_IDLE;
      byte_index_next   = '0;
      res_valid         = 1'b1;
      res.payload_valid = finish_pv;
      res.out_byte      = finish_pv ? b : 8'h00;
      res.req_type      = f_type;
      res.req_sequence  = f_seq;
      res.req_length    = f_len[ccrfr_pkg::IDX_W-1:0];
      if (~crc_upd != f_crc) begin
        cache_valid_next = 1'b0;
        res.verdict      = ccrfr_pkg::V_CRC;
      end else if (cache_valid && f_seq == cache_sequence && f_type == cache_type &&
                   f_crc == cache_crc) begin
        res.verdict = ccrfr_pkg::V_REPLAY;
      end else begin
        cache_valid_next    = 1'b1;
        cache_sequence_next = f_seq;
        cache_type_next     = f_type;
        cache_crc_next      = f_crc;
        res.verdict         = ccrfr_pkg::V_DISPATCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_magic   <= '0;
      hdr_version   <= '0;
      timeout_ticks <= ccrfr_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ccrfr_pkg::CFG_MAGIC:   frame_magic   <= cfg_data;
        ccrfr_pkg::CFG_VERSION: hdr_version   <= cfg_data[7:0];
        ccrfr_pkg::CFG_TIMEOUT: timeout_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ccrfr_pkg::PH_IDLE;
      byte_index     <= '0;
      running_crc    <= ccrfr_pkg::CRC_INIT;
      idle_ticks     <= '0;
      cache_valid    <= 1'b0;
      cache_sequence <= '0;
      cache_type     <= '0;
      cache_crc      <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      byte_index     <= byte_index_next;
      running_crc    <= running_crc_next;
      idle_ticks     <= idle_ticks_next;
      cache_valid    <= cache_valid_next;
      cache_sequence <= cache_sequence_next;
      cache_type     <= cache_type_next;
      cache_crc      <= cache_crc_next;
    end
  end

  // header capture; in idle byte_index is zero, so a frame start lands in entry 0
  always_ff @(posedge clk) begin
    if (fire && is_byte && phase != ccrfr_pkg::PH_PAYLOAD) begin
      header_store[byte_index[ccrfr_pkg::HDR_IDX_W-1:0]] <= b;
    end
  end

  assign hdr_idx_ok  = (byte_index != '0) && (byte_index <= ccrfr_pkg::HDR_LAST_IDX);
  assign replay_fire = fire && res_valid && (res.verdict == ccrfr_pkg::V_REPLAY);
  assign pass_clean  = !res.payload_valid && (res.verdict == ccrfr_pkg::V_NONE);

  `CCRFR_ASSERT_IMPLIES(a_idle_index_zero, phase == ccrfr_pkg::PH_IDLE, byte_index == '0)
  `CCRFR_ASSERT_IMPLIES(a_header_index_range, phase == ccrfr_pkg::PH_HEADER, hdr_idx_ok)
  `CCRFR_ASSERT_NEXT(a_replay_keeps_cache, replay_fire, cache_valid)
  `CCRFR_ASSERT_IMPLIES(a_passthrough_clean, res_valid && res.passthrough, pass_clean)

endmodule

// ----- hw/rtl/ccrfr_out_stage.sv -----
module ccrfr_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic                res_valid,
  input  ccrfr_pkg::result_t  res,
  input  logic                out_ready,
  output logic                out_valid,
  output ccrfr_pkg::result_t  res_q,
  output logic                slot_free
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_q <= res;
    end
  end

endmodule

// ----- hw/rtl/crc_checked_request_frame_receiver_core.sv -----
// Request frame receiver. Each input transfer is a link byte (opcode 0) or a
// millisecond tick (opcode 1). Idle bytes other than the low byte of
// frame_magic are passed through; the magic low byte starts a 20-byte
// little-endian header, which is checked and then followed by a payload that
// streams out byte by byte while a reflected CRC-32 runs over header bytes
// 0..15 and the payload. Each frame ends in one verdict: dispatch, replay of
// the cached request, bad length or timeout, or CRC mismatch. Bad headers and
// header timeouts are dropped with no output. The block takes one transfer
// per clock while no result waits in the output register; a transfer is held
// in the input register, and any result then goes to the output register.
// The per-byte CRC update (eight shift/xor steps) plus field capture
// is the longest path. Any transfer, including one that yields no result,
// waits while the output register holds a result that has not been taken.
// Configuration writes are only legal while no frame is in progress.
module crc_checked_request_frame_receiver_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             opcode,
  input  logic [7:0]                       rx_byte,
  input  logic                             cfg_write,
  input  logic [ccrfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             passthrough,
  output logic                             payload_valid,
  output logic [7:0]                       out_byte,
  output logic [2:0]                       verdict,
  output logic [6:0]                       req_type,
  output logic [31:0]                      req_sequence,
  output logic [ccrfr_pkg::IDX_W-1:0]      req_length
);

  ccrfr_pkg::item_t    in_item;
  ccrfr_pkg::item_t    item;
  logic                item_valid;
  logic                slot_free;
  logic                fire;
  logic                res_valid;
  ccrfr_pkg::result_t  res;
  ccrfr_pkg::result_t  res_q;

  assign in_item.opcode  = opcode;
  assign in_item.rx_byte = rx_byte;
  assign fire            = item_valid && slot_free;

  ccrfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (fire),
    .slot_free  (slot_free),
    .item_valid (item_valid),
    .item       (item)
  );

  ccrfr_frame_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  ccrfr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_q     (res_q),
    .slot_free (slot_free)
  );

  assign passthrough   = res_q.passthrough;
  assign payload_valid = res_q.payload_valid;
  assign out_byte      = res_q.out_byte;
  assign verdict       = res_q.verdict;
  assign req_type      = res_q.req_type;
  assign req_sequence  = res_q.req_sequence;
  assign req_length    = res_q.req_length;

endmodule
